>>> hw/rtl/aphr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aphr_pkg
// Types and constants shared by the audio packet header repacker.
// ----------------------------------------------------------------------------
package aphr_pkg;

  localparam int HEADER_BYTES    = 2;
  localparam int MODE_TABLE_SIZE = 64;
  localparam int FIFO_DEPTH      = 4;

  // byte position codes within a packet
  localparam logic [1:0] POS_HDR0  = 2'd0;
  localparam logic [1:0] POS_HDR1  = 2'd1;
  localparam logic [1:0] POS_FIRST = 2'd2;
  localparam logic [1:0] POS_BODY  = 2'd3;

  // register addresses
  localparam logic [3:0] ADDR_MODE_WIDTH = 4'h0;
  localparam logic [3:0] ADDR_MODE_FLAGS = 4'h8;

  // words produced by one input word, handed to the output queue
  typedef struct packed {
    logic [1:0] n;      // number of words to queue: 0, 1 or 2
    logic [7:0] byte0;  // body word, never last
    logic [7:0] byte1;  // padded flush word, always last
  } aphr_push_t;

endpackage

>>> hw/rtl/aphr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aphr_in_if / aphr_out_if
// Valid/ready channels for raw packet words and repacked packet words.
// ----------------------------------------------------------------------------
interface aphr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface aphr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

>>> hw/rtl/audio_packet_header_repacker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_packet_header_repacker_top
// Rewrites compact audio packets into standard packets, one word at a time.
// ----------------------------------------------------------------------------
// One input word is taken per cycle while the output queue has room. Each
// word passes an input register and one stage of shift-and-merge logic, so its
// results are written into the output queue once it has room and show on the
// port straight away. The two header words of a packet give nothing, a payload
// word gives one word and the last word of a packet gives two (its own and the
// zero-padded flush word), so sustained throughput is one word per cycle while
// the output is ready, set by the single output port; the four-entry output
// queue lets input continue while a result waits.
// Registers: mode_width at byte address 0x0, mode_flags at 0x8 (64-bit data).
module audio_packet_header_repacker_top
  import aphr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  aphr_in_if.sink     in_s,
  aphr_out_if.source  out_m,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [2:0]  mode_width_r;
  logic [63:0] mode_flags_r;
  logic        wr_en;
  logic        room;
  aphr_push_t  push;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_width_r <= 3'd0;
      mode_flags_r <= 64'd0;
    end else if (wr_en) begin
      if (paddr == ADDR_MODE_WIDTH) begin
        mode_width_r <= pwdata[2:0];
      end
      if (paddr == ADDR_MODE_FLAGS) begin
        mode_flags_r <= pwdata;
      end
    end
  end

  always_comb begin
    case (paddr)
      ADDR_MODE_WIDTH: prdata = {61'd0, mode_width_r};
      ADDR_MODE_FLAGS: prdata = mode_flags_r;
      default:         prdata = 64'd0;
    endcase
  end

  aphr_repack u_repack (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_s       (in_s),
    .room       (room),
    .mode_width (mode_width_r),
    .mode_flags (mode_flags_r),
    .push       (push)
  );

  aphr_out_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .room  (room),
    .out_m (out_m)
  );

endmodule

>>> hw/rtl/aphr_repack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aphr_repack
// Input register, packet position state and the bit shift-and-merge.
// ----------------------------------------------------------------------------
module aphr_repack
  import aphr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  aphr_in_if.sink     in_s,
  input  logic        room,
  input  logic [2:0]  mode_width,
  input  logic [63:0] mode_flags,
  output aphr_push_t  push
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  logic [1:0] pos_r,   pos_nxt;
  logic [2:0] carry_r, carry_nxt;
  logic [1:0] ccnt_r,  ccnt_nxt;
  logic       prev_r,  prev_nxt;

  logic        fire;
  logic        is_hdr;
  logic        is_first;
  logic        hdr_skip;
  logic [7:0]  b;
  logic [7:0]  mask;
  logic [7:0]  mode;
  logic [7:0]  rem;
  logic        flag;
  logic [3:0]  n0;
  logic [10:0] acc_f;
  logic [10:0] acc_l;
  logic [10:0] acc;

  assign fire       = in_vld_r && room;
  assign in_s.ready = !in_vld_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_s.ready) begin
      in_vld_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.ready && in_s.valid) begin
      in_byte_r <= in_s.data_byte;
      in_last_r <= in_s.last_byte;
    end
  end

  always_comb begin
    is_hdr   = (pos_r == POS_HDR0) || (pos_r == POS_HDR1);
    is_first = is_hdr || (pos_r == POS_FIRST);
    hdr_skip = is_hdr && !in_last_r;
    // a packet cut short in its header behaves as first payload word zero
    b        = is_hdr ? 8'h00 : in_byte_r;
    mask     = ~(8'hFF << mode_width);
    mode     = b & mask;
    rem      = b >> mode_width;
    flag     = (mode < 8'(MODE_TABLE_SIZE)) && mode_flags[mode[5:0]];
    n0       = 4'(mode_width) + 4'd1;
    // type bit is zero, then mode, then optional prev flag and a zero next-flag bit, then remainder
    acc_f    = (11'(mode) << 1)
             | (flag ? (11'(prev_r) << n0) : 11'd0)
             | (11'(rem) << (flag ? (n0 + 4'd2) : n0));
    acc_l    = 11'(carry_r) | (11'(in_byte_r) << ccnt_r);
    acc      = is_first ? acc_f : acc_l;
  end

  always_comb begin
    pos_nxt   = pos_r;
    carry_nxt = carry_r;
    ccnt_nxt  = ccnt_r;
    prev_nxt  = prev_r;
    push.n     = 2'd0;
    push.byte0 = acc[7:0];
    push.byte1 = {5'd0, acc[10:8]};
    if (fire) begin
      if (hdr_skip) begin
        pos_nxt = pos_r + 2'd1;
      end else begin
        if (is_first) begin
          prev_nxt = flag;
        end
        if (in_last_r) begin
          push.n    = 2'd2;
          pos_nxt   = POS_HDR0;
          carry_nxt = 3'd0;
          ccnt_nxt  = 2'd0;
        end else begin
          push.n    = 2'd1;
          pos_nxt   = POS_BODY;
          carry_nxt = acc[10:8];
          if (is_first) begin
            ccnt_nxt = flag ? 2'd3 : 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_HDR0;
      carry_r <= 3'd0;
      ccnt_r  <= 2'd0;
      prev_r  <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      carry_r <= carry_nxt;
      ccnt_r  <= ccnt_nxt;
      prev_r  <= prev_nxt;
    end
  end

endmodule

>>> hw/rtl/aphr_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aphr_out_fifo
// Small result queue taking up to two words per cycle, giving one while the output is ready.
// ----------------------------------------------------------------------------
module aphr_out_fifo
  import aphr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  aphr_push_t push,
  output logic       room,
  aphr_out_if.source out_m
);

  localparam int PW = $clog2(FIFO_DEPTH);

  logic [8:0]    mem_r [FIFO_DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          pop;

  // two free entries needed, as the last word of a packet queues two
  assign room           = cnt_r <= (PW+1)'(FIFO_DEPTH - 2);
  assign out_m.valid    = cnt_r != '0;
  assign out_m.out_byte = mem_r[rd_r][7:0];
  assign out_m.out_last = mem_r[rd_r][8];
  assign pop            = out_m.valid && out_m.ready;

  always_comb begin
    wr_nxt  = wr_r + PW'(push.n);
    rd_nxt  = rd_r + PW'(pop);
    cnt_nxt = cnt_r + (PW+1)'(push.n) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_r] <= {1'b0, push.byte0};
    end
    if (push.n == 2'd2) begin
      mem_r[wr_r + PW'(1)] <= {1'b1, push.byte1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/aphr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aphr_checker
// Port-level checks on the repacker, bound to the top level.
// ----------------------------------------------------------------------------
module aphr_checker
  import aphr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_last,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [63:0] pwdata,
  input logic [63:0] prdata,
  input logic        pready
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output word changed while stalled");

  // queue is empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // flush word carries at most three spare bits
  a_flush_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_byte[7:3] == 5'd0)
    else $error("flush word has bits above the carry");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

  // mode width read back after a write to it
  a_mode_rd: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && paddr == ADDR_MODE_WIDTH |=>
      paddr != ADDR_MODE_WIDTH ||
      prdata[2:0] == $past(pwdata[2:0]) || (psel && penable && pwrite))
    else $error("mode width read back wrong");

endmodule

bind audio_packet_header_repacker_top aphr_checker u_aphr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_m.valid),
  .out_ready (out_m.ready),
  .out_byte  (out_m.out_byte),
  .out_last  (out_m.out_last),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);
